/* design/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FREE  = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BASE   = 2'd2;

    // Field widths and bit positions.
    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 5;
    localparam int MASK_W  = 32;
    localparam int COUNT_W = 6;
    localparam int SIZE_W  = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;
    localparam int TUSER_W   = 2;

    // Quotient bits resolved by the divider; a quotient of 32 or more is
    // always out of range.
    localparam int QUOT_W = 5;
    localparam int REM_W  = SIZE_W + QUOT_W;

    localparam logic [SIZE_W-1:0] SIZE_MIN         = 16'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX_ALIGNED = 16'd65528;
    localparam logic [SIZE_W-1:0] ALIGN_MASK       = 16'h0007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADD_BASE,
        ST_RANGE,
        ST_DIV,
        ST_FINISH,
        ST_EMIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic add_base;
        logic div_init;
        logic div_step;
        logic free_finish;
        logic load_out;
    } bba_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        func_t func;
        logic  pool_empty;
        logic  addr_zero;
        logic  range_bad;
        logic  div_last;
        logic  out_free;
    } bba_stat_t;

endpackage

/* design/bba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer that steps one item at a time through execute, address add,
// range check, quotient steps and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);
    import bba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.func == FUNC_ALLOC && !stat.pool_empty) begin
                    state_next = ST_ADD_BASE;
                end else if (stat.func == FUNC_FREE && !stat.addr_zero) begin
                    state_next = ST_RANGE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_ADD_BASE: begin
                cmd.add_base = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_RANGE: begin
                cmd.div_init = 1'b1;
                state_next   = stat.range_bad ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.free_finish = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/bba_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Configuration registers, free bitmap, lowest-free search, block address
// multiply-add, restoring quotient unit and the output register.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [bba_pkg::TUSER_W-1:0]         in_func,
    input  logic [bba_pkg::ADDR_W-1:0]          in_address,
    input  logic                                m_tready,
    output logic                                out_valid,
    output logic [bba_pkg::TUSER_W-1:0]         out_status,
    output logic [bba_pkg::ADDR_W-1:0]          out_block_address,
    output logic [bba_pkg::INDEX_W-1:0]         out_block_index,
    output logic [bba_pkg::MASK_W-1:0]          out_free_mask,
    input  bba_pkg::bba_cmd_t                   cmd,
    output bba_pkg::bba_stat_t                  stat
);
    import bba_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BLOCKS);

    logic [SIZE_W-1:0]     size_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [ADDR_W-1:0]     base_reg;
    logic [MAX_BLOCKS-1:0] bitmap_reg, bitmap_next;

    func_t               func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   off_reg;
    logic [REM_W-1:0]    mul_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]   q_reg;
    logic [2:0]          step_reg;

    status_t             res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [INDEX_W-1:0]  res_index_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [MASK_W-1:0]   out_mask_reg;

    logic [SIZE_W-1:0]     size_fix;
    logic [SIZE_W-1:0]     size_sum;
    logic [COUNT_W-1:0]    count_fix;
    logic [MAX_BLOCKS-1:0] full_mask_cur;
    logic [MAX_BLOCKS-1:0] full_mask_cfg;
    logic [MAX_BLOCKS-1:0] lowest;
    logic [MAX_BLOCKS-1:0] q_onehot;
    logic [INDEX_W-1:0]    alloc_idx;
    logic [REM_W-1:0]      divisor_shift;
    logic                  rem_ge;
    logic                  quot_bad;

    // Register write sanitizing: size rounds up to a multiple of eight, clamped to 8..65528.
    assign size_sum  = cfg_wr_data[SIZE_W-1:0] + ALIGN_MASK;
    assign count_fix = (cfg_wr_data[COUNT_W-1:0] > MAX_COUNT) ? MAX_COUNT
                                                              : cfg_wr_data[COUNT_W-1:0];
    always_comb begin
        if (cfg_wr_data[SIZE_W-1:0] == '0) begin
            size_fix = SIZE_MIN;
        end else if (cfg_wr_data[SIZE_W-1:0] > SIZE_MAX_ALIGNED) begin
            size_fix = SIZE_MAX_ALIGNED;
        end else begin
            size_fix = size_sum & ~ALIGN_MASK;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            full_mask_cur[i] = (COUNT_W'(i) < count_reg);
            full_mask_cfg[i] = (COUNT_W'(i) < count_fix);
            q_onehot[i]      = (QUOT_W'(i) == q_reg);
        end
    end

    // Isolate the lowest free bit, then encode it bit by bit.
    assign lowest = bitmap_reg & (~bitmap_reg + MAX_BLOCKS'(1));
    always_comb begin
        alloc_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (lowest[i]) begin
                alloc_idx = alloc_idx | INDEX_W'(i);
            end
        end
    end

    assign divisor_shift = REM_W'(size_reg) << step_reg;
    assign rem_ge        = (rem_reg >= divisor_shift);
    assign quot_bad      = ({1'b0, q_reg} >= count_reg);

    always_comb begin
        bitmap_next = bitmap_reg;
        if (cfg_wr_en && cfg_index == CFG_BLOCK_COUNT) begin
            // A new block count re-creates the pool with every block free.
            bitmap_next = full_mask_cfg;
        end else if (cmd.exec) begin
            case (func_reg)
                FUNC_ALLOC: bitmap_next = bitmap_reg & ~lowest;
                FUNC_RESET: bitmap_next = full_mask_cur;
                default:    bitmap_next = bitmap_reg;
            endcase
        end else if (cmd.free_finish && !quot_bad) begin
            bitmap_next = bitmap_reg | q_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= SIZE_MIN;
            count_reg  <= MAX_COUNT;
            base_reg   <= '0;
            bitmap_reg <= '1;
        end else begin
            bitmap_reg <= bitmap_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BLOCK_SIZE:  size_reg  <= size_fix;
                    CFG_BLOCK_COUNT: count_reg <= count_fix;
                    CFG_POOL_BASE:   base_reg  <= cfg_wr_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= func_t'(in_func);
            addr_reg <= in_address;
        end
        if (cmd.exec) begin
            res_addr_reg   <= '0;
            res_index_reg  <= '0;
            res_status_reg <= STATUS_OK;
            off_reg        <= addr_reg - base_reg;
            mul_reg        <= REM_W'(size_reg) * REM_W'(alloc_idx);
            if (func_reg == FUNC_ALLOC) begin
                if (bitmap_reg == '0) begin
                    res_status_reg <= STATUS_NO_FREE;
                end else begin
                    res_index_reg <= alloc_idx;
                end
            end
        end
        if (cmd.add_base) begin
            res_addr_reg <= base_reg + ADDR_W'(mul_reg);
        end
        if (cmd.div_init) begin
            rem_reg  <= off_reg[REM_W-1:0];
            q_reg    <= '0;
            step_reg <= 3'(QUOT_W - 1);
            if (stat.range_bad) begin
                res_status_reg <= STATUS_BAD_ADDR;
            end
        end
        if (cmd.div_step) begin
            q_reg    <= {q_reg[QUOT_W-2:0], rem_ge};
            step_reg <= step_reg - 3'd1;
            if (rem_ge) begin
                rem_reg <= rem_reg - divisor_shift;
            end
        end
        if (cmd.free_finish) begin
            if (quot_bad) begin
                res_status_reg <= STATUS_BAD_ADDR;
            end else begin
                res_index_reg <= q_reg;
            end
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_index_reg  <= res_index_reg;
            out_mask_reg   <= MASK_W'(bitmap_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // An offset of 32 blocks or more can never be a valid index.
    assign stat.range_bad  = (off_reg[ADDR_W-1:REM_W] != '0) ||
                             (off_reg[REM_W-1:0] >= {size_reg, {QUOT_W{1'b0}}});
    assign stat.func       = func_reg;
    assign stat.pool_empty = (bitmap_reg == '0);
    assign stat.addr_zero  = (addr_reg == '0);
    assign stat.div_last   = (step_reg == '0);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_block_address = out_addr_reg;
    assign out_block_index   = out_index_reg;
    assign out_free_mask     = out_mask_reg;

endmodule

/* design/bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// An alloc passes execute, address add and emit (execute and emit if the pool is
// empty); reset, no-op or a free of address zero pass execute and emit; a free
// whose offset is 32 blocks or more passes execute, range and emit; other frees
// add five quotient steps and finish. Items go one at a time; an output stall
// holds the result load, and the next item is taken the cycle after that load.
// Synchronous active-low reset: block size 8, 32 blocks, base 0, all free.
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block allocator over a free bitmap with alloc, free and reset.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: address[31:0]
    input  logic [bba_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: func[1:0]
    input  logic [bba_pkg::TUSER_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: block_address[31:0], block_index[36:32], free_mask[68:37], zero pad
    output logic [bba_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: status[1:0]
    output logic [bba_pkg::TUSER_W-1:0]       m_tuser
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    logic [ADDR_W-1:0]  out_block_address;
    logic [INDEX_W-1:0] out_block_index;
    logic [MASK_W-1:0]  out_free_mask;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .in_func           (s_tuser),
        .in_address        (s_tdata[ADDR_W-1:0]),
        .m_tready          (m_tready),
        .out_valid         (m_tvalid),
        .out_status        (m_tuser),
        .out_block_address (out_block_address),
        .out_block_index   (out_block_index),
        .out_free_mask     (out_free_mask),
        .cmd               (cmd),
        .stat              (stat)
    );

    assign m_tdata = {{(M_TDATA_W - ADDR_W - INDEX_W - MASK_W){1'b0}},
                      out_free_mask, out_block_index, out_block_address};

endmodule

/* design/bba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator's result channel.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bba_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [bba_pkg::TUSER_W-1:0]       m_tuser
);
    import bba_pkg::*;

    // A held result must not be dropped before it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A failed item reports neither an address nor an index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata[36:0] == '0))
        else $error("failed result carries an address or index");

    // An empty pool report means no block is free afterwards.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_NO_FREE) |-> (m_tdata[68:37] == '0))
        else $error("no-free status with a nonzero free mask");

    // A stalled result keeps its contents until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The input side does not stay open after accepting an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while the first is in flight");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
